@@ src/bud_pkg.sv @@
package bud_pkg;

    localparam int MIN_ORDER    = 6;
    localparam int MAX_ORDER    = 16;
    localparam int HEADER_BYTES = 24;
    localparam int REQ_W        = 16;
    localparam int SLOT_W       = MAX_ORDER - MIN_ORDER;
    localparam int SLOTS        = 1 << SLOT_W;
    localparam int LINK_W       = SLOT_W + 1;
    localparam int ORD_W        = 5;
    localparam int NUM_LISTS    = MAX_ORDER + 1;
    localparam int RESET_ORDER  = 16;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

    typedef enum logic [1:0] {
        TAG_UNUSED,
        TAG_FREE,
        TAG_RESERVED
    } t_tag;

    typedef enum logic {
        OP_ALLOC,
        OP_FREE
    } t_op;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NOMEM,
        ST_IGNORED
    } t_status;

    typedef struct packed {
        t_tag              tag;
        logic [ORD_W-1:0]  order;
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
    } t_slot;

    typedef struct packed {
        logic              zero_req;
        logic [ORD_W-1:0]  need_order;
        logic              free_ok;
        logic [SLOT_W-1:0] free_slot;
    } t_dec;

    typedef struct packed {
        t_status          status;
        logic [REQ_W-1:0] payload;
    } t_res;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_A_HEAD,
        S_A_RD,
        S_A_MARK,
        S_A_CHK,
        S_F_RD,
        S_F_LOOP,
        S_F_BUD,
        S_F_ABS,
        S_F_DONE,
        S_U0,
        S_U1,
        S_U2,
        S_U3,
        S_P0,
        S_P1,
        S_RESULT
    } t_state;

endpackage

@@ src/bud_in_if.sv @@
interface bud_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] request_bytes;
    logic [15:0] address;

    modport source (output valid, output opcode, output request_bytes, output address,
                    input ready);
    modport sink (input valid, input opcode, input request_bytes, input address,
                  output ready);
endinterface

@@ src/bud_out_if.sv @@
interface bud_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] payload_offset;

    modport source (output valid, output status, output payload_offset, input ready);
    modport sink (input valid, input status, input payload_offset, output ready);
endinterface

@@ src/bud_decode.sv @@
module bud_decode (
    input  logic [bud_pkg::REQ_W-1:0] i_request_bytes,
    input  logic [bud_pkg::REQ_W-1:0] i_address,
    input  logic [bud_pkg::ORD_W-1:0] i_top,
    output bud_pkg::t_dec             o_dec
);
    import bud_pkg::*;

    logic [REQ_W+1:0] w_bytes;
    logic [REQ_W-1:0] w_off;
    logic [ORD_W-1:0] w_need;

    assign w_bytes = (REQ_W+2)'(i_request_bytes) + (REQ_W+2)'(HEADER_BYTES);
    assign w_off   = i_address - REQ_W'(HEADER_BYTES);

    always_comb begin
        w_need = ORD_W'(REQ_W + 1);
        for (int i = REQ_W + 1; i >= MIN_ORDER; i--) begin
            if (w_bytes <= ((REQ_W+2)'(1) << i)) begin
                w_need = ORD_W'(i);
            end
        end
    end

    always_comb begin
        o_dec.zero_req   = (i_request_bytes == '0);
        o_dec.need_order = w_need;
        o_dec.free_ok    = (i_address >= REQ_W'(HEADER_BYTES)) &&
                           (w_off[MIN_ORDER-1:0] == '0) &&
                           (((REQ_W+1)'(w_off) >> i_top) == '0);
        o_dec.free_slot  = w_off[MIN_ORDER +: SLOT_W];
    end

endmodule

@@ src/bud_engine.sv @@
module bud_engine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_start,
    input  logic [bud_pkg::ORD_W-1:0] i_top,
    input  logic                      i_item_valid,
    output logic                      o_item_ready,
    input  bud_pkg::t_op              i_op,
    input  bud_pkg::t_dec             i_dec,
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output bud_pkg::t_res             o_res
);
    import bud_pkg::*;

    t_slot             mem [SLOTS];
    t_slot             r_rdata;

    t_state            r_state, n_state;
    t_state            r_ret, n_ret;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic              r_sweep_all, n_sweep_all;
    logic [SLOT_W-1:0] r_s, n_s;
    logic [SLOT_W-1:0] r_b, n_b;
    logic [ORD_W-1:0]  r_k, n_k;
    logic [ORD_W-1:0]  r_j, n_j;
    logic [ORD_W-1:0]  r_lk, n_lk;
    t_slot             r_ent, n_ent;
    t_res              r_res, n_res;
    logic [LINK_W-1:0] r_head [NUM_LISTS];

    logic              w_we, w_re, w_head_we, w_head_init, w_found;
    logic [SLOT_W-1:0] w_waddr, w_raddr;
    t_slot             w_wdata;
    logic [LINK_W-1:0] w_head_wd, w_h;
    logic [NUM_LISTS-1:0] w_ne;
    logic [ORD_W-1:0]  w_j, w_jm1;

    always_comb begin
        for (int i = 0; i < NUM_LISTS; i++) begin
            w_ne[i] = (r_head[i] != NIL);
        end
    end

    always_comb begin
        w_found = 1'b0;
        w_j     = i_dec.need_order;
        for (int i = 0; i < NUM_LISTS; i++) begin
            if (!w_found && w_ne[i] && ORD_W'(i) >= i_dec.need_order && ORD_W'(i) <= i_top) begin
                w_found = 1'b1;
                w_j     = ORD_W'(i);
            end
        end
    end

    assign w_h   = r_head[r_lk];
    assign w_jm1 = r_j - ORD_W'(1);

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_cnt       = r_cnt;
        n_sweep_all = r_sweep_all;
        n_s         = r_s;
        n_b         = r_b;
        n_k         = r_k;
        n_j         = r_j;
        n_lk        = r_lk;
        n_ent       = r_ent;
        n_res       = r_res;
        w_we        = 1'b0;
        w_waddr     = r_s;
        w_wdata     = '0;
        w_re        = 1'b0;
        w_raddr     = r_s;
        w_head_we   = 1'b0;
        w_head_wd   = NIL;
        w_head_init = 1'b0;
        o_item_ready = 1'b0;
        o_res_valid  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_cnt;
                if (r_cnt == '0) begin
                    w_wdata     = t_slot'{TAG_FREE, i_top, NIL, NIL};
                    w_head_init = 1'b1;
                end
                n_cnt = r_cnt + SLOT_W'(1);
                if (!r_sweep_all || (&r_cnt)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    n_res = t_res'{ST_IGNORED, '0};
                    if (i_op == OP_ALLOC) begin
                        if (i_dec.zero_req) begin
                            n_state = S_RESULT;
                        end else if (i_dec.need_order > i_top || !w_found) begin
                            n_res   = t_res'{ST_NOMEM, '0};
                            n_state = S_RESULT;
                        end else begin
                            n_lk    = w_j;
                            n_j     = w_j;
                            n_k     = i_dec.need_order;
                            n_state = S_A_HEAD;
                        end
                    end else begin
                        if (!i_dec.free_ok) begin
                            n_state = S_RESULT;
                        end else begin
                            w_re    = 1'b1;
                            w_raddr = i_dec.free_slot;
                            n_s     = i_dec.free_slot;
                            n_state = S_F_RD;
                        end
                    end
                end
            end
            S_A_HEAD: begin
                n_s     = w_h[SLOT_W-1:0];
                w_re    = 1'b1;
                w_raddr = w_h[SLOT_W-1:0];
                n_state = S_A_RD;
            end
            S_A_RD: begin
                n_ent   = r_rdata;
                n_ret   = S_A_MARK;
                n_state = S_U0;
            end
            S_A_MARK: begin
                w_we    = 1'b1;
                w_waddr = r_s;
                w_wdata = t_slot'{TAG_RESERVED, r_k, NIL, NIL};
                n_state = S_A_CHK;
            end
            S_A_CHK: begin
                if (r_j > r_k) begin
                    n_j     = w_jm1;
                    n_lk    = w_jm1;
                    n_b     = r_s + (SLOT_W'(1) << (w_jm1 - ORD_W'(MIN_ORDER)));
                    n_ret   = S_A_CHK;
                    n_state = S_P0;
                end else begin
                    n_res   = t_res'{ST_OK, {r_s, {MIN_ORDER{1'b0}}} + REQ_W'(HEADER_BYTES)};
                    n_state = S_RESULT;
                end
            end
            S_F_RD: begin
                if (r_rdata.tag != TAG_RESERVED) begin
                    n_state = S_RESULT;
                end else begin
                    n_k     = (r_rdata.order < ORD_W'(MIN_ORDER)) ? ORD_W'(MIN_ORDER)
                                                                  : r_rdata.order;
                    n_state = S_F_LOOP;
                end
            end
            S_F_LOOP: begin
                if (r_k < i_top) begin
                    n_b     = r_s ^ (SLOT_W'(1) << (r_k - ORD_W'(MIN_ORDER)));
                    w_re    = 1'b1;
                    w_raddr = n_b;
                    n_state = S_F_BUD;
                end else begin
                    n_b     = r_s;
                    n_lk    = r_k;
                    n_ret   = S_F_DONE;
                    n_state = S_P0;
                end
            end
            S_F_BUD: begin
                if (r_rdata.tag == TAG_FREE && r_rdata.order == r_k) begin
                    n_ent   = r_rdata;
                    n_lk    = r_k;
                    n_ret   = S_F_ABS;
                    n_state = S_U0;
                end else begin
                    n_b     = r_s;
                    n_lk    = r_k;
                    n_ret   = S_F_DONE;
                    n_state = S_P0;
                end
            end
            S_F_ABS: begin
                w_we = 1'b1;
                if (r_b < r_s) begin
                    w_waddr = r_s;
                    n_s     = r_b;
                end else begin
                    w_waddr = r_b;
                end
                n_k     = r_k + ORD_W'(1);
                n_state = S_F_LOOP;
            end
            S_F_DONE: begin
                n_res   = t_res'{ST_OK, '0};
                n_state = S_RESULT;
            end
            S_U0: begin
                if (r_ent.prev != NIL) begin
                    w_re    = 1'b1;
                    w_raddr = r_ent.prev[SLOT_W-1:0];
                    n_state = S_U1;
                end else begin
                    w_head_we = 1'b1;
                    w_head_wd = r_ent.next;
                    n_state   = S_U2;
                end
            end
            S_U1: begin
                w_we         = 1'b1;
                w_waddr      = r_ent.prev[SLOT_W-1:0];
                w_wdata      = r_rdata;
                w_wdata.next = r_ent.next;
                n_state      = S_U2;
            end
            S_U2: begin
                if (r_ent.next != NIL) begin
                    w_re    = 1'b1;
                    w_raddr = r_ent.next[SLOT_W-1:0];
                    n_state = S_U3;
                end else begin
                    n_state = r_ret;
                end
            end
            S_U3: begin
                w_we         = 1'b1;
                w_waddr      = r_ent.next[SLOT_W-1:0];
                w_wdata      = r_rdata;
                w_wdata.prev = r_ent.prev;
                n_state      = r_ret;
            end
            S_P0: begin
                w_we      = 1'b1;
                w_waddr   = r_b;
                w_wdata   = t_slot'{TAG_FREE, r_lk, w_h, NIL};
                w_head_we = 1'b1;
                w_head_wd = {1'b0, r_b};
                n_ent.next = w_h;
                if (w_h != NIL) begin
                    w_re    = 1'b1;
                    w_raddr = w_h[SLOT_W-1:0];
                    n_state = S_P1;
                end else begin
                    n_state = r_ret;
                end
            end
            S_P1: begin
                w_we         = 1'b1;
                w_waddr      = r_ent.next[SLOT_W-1:0];
                w_wdata      = r_rdata;
                w_wdata.prev = {1'b0, r_b};
                n_state      = r_ret;
            end
            S_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_start) begin
            n_state     = S_CLEAR;
            n_cnt       = '0;
            n_sweep_all = 1'b1;
        end
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_sweep_all <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sweep_all <= n_sweep_all;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;
        r_s   <= n_s;
        r_b   <= n_b;
        r_k   <= n_k;
        r_j   <= n_j;
        r_lk  <= n_lk;
        r_ent <= n_ent;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (w_head_init) begin
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_head[i] <= (ORD_W'(i) == i_top) ? '0 : NIL;
            end
        end else if (w_head_we) begin
            r_head[r_lk] <= w_head_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    a_no_list_above_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR && !$past(i_cfg_start)) |->
        (NUM_LISTS'(w_ne >> (i_top + ORD_W'(1))) == '0))
        else $error("free list above pool order is not empty");

    a_item_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item_valid && o_item_ready) |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

    a_buddy_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_F_ABS) |-> (r_b != r_s))
        else $error("buddy equals block being freed");

endmodule

@@ src/buddy_allocator.sv @@
// Channel | Dir | Handshake         | Payload
// i_req   | in  | valid/ready       | opcode, request_bytes, address
// o_rsp   | out | valid/ready       | status, payload_offset
// i_cfg   | in  | write enable only | i_cfg_wdata = pool_order
//
// One item at a time: an allocate splits a free block level by level and a free merges with
// its buddy level by level, each step being a read-modify-write of the slot memory.
// The result sits in an output register, so the next item is taken while it waits.
// After reset, slot 0 is written before items are taken.
// A configuration write clears the whole slot memory, with no item accepted during the sweep.
module buddy_allocator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [4:0]       i_cfg_wdata,
    bud_in_if.sink           i_req,
    bud_out_if.source        o_rsp
);
    import bud_pkg::*;

    logic [4:0]       r_pool_order;
    logic [ORD_W-1:0] w_top;
    t_dec             w_dec;
    t_res             w_res;
    t_res             r_out;
    logic             r_out_valid;
    logic             w_res_valid, w_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_order <= 5'(RESET_ORDER);
        end else if (i_cfg_we) begin
            r_pool_order <= i_cfg_wdata;
        end
    end

    assign w_top = (r_pool_order < 5'(MIN_ORDER)) ? ORD_W'(MIN_ORDER) :
                   (r_pool_order > 5'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : r_pool_order;

    bud_decode u_decode (
        .i_request_bytes (i_req.request_bytes),
        .i_address       (i_req.address),
        .i_top           (w_top),
        .o_dec           (w_dec)
    );

    bud_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_start  (i_cfg_we),
        .i_top        (w_top),
        .i_item_valid (i_req.valid),
        .o_item_ready (i_req.ready),
        .i_op         (t_op'(i_req.opcode)),
        .i_dec        (w_dec),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res)
    );

    assign w_res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.payload_offset = r_out.payload;

endmodule
